[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/pkol_pkg.sv]
// ----------------------------------------------------------------------------
// Occupancy ledger package
// Word types, command and status codes and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pkol_pkg;

  localparam int REG_COUNT        = 8;
  localparam int DEF_NUM_KINDS    = 8;
  localparam int DEF_MAX_CAPACITY = 1000000;
  localparam int DEF_REJECT_WIDTH = 32;

  localparam int CAP_W     = 20;
  localparam int CFG_IDX_W = 4;
  localparam int REJ_OUT_W = 32;

  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_RELEASED  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_SNAPSHOT  = 3'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] kind_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [CAP_W-1:0]     occupancy_out;
    logic [CAP_W-1:0]     capacity_out;
    logic [REJ_OUT_W-1:0] rejected_out;
  } out_word_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CAP_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic     en;
    in_word_t word;
  } bank_req_t;

endpackage

[src/pkol_bank.sv]
// ----------------------------------------------------------------------------
// Occupancy ledger counter bank
// Capacity, occupancy and rejection registers per kind, with the command
// decode that reads one kind and updates it in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkol_bank import pkol_pkg::*; #(
  parameter int NUM_KINDS    = DEF_NUM_KINDS,
  parameter int MAX_CAPACITY = DEF_MAX_CAPACITY,
  parameter int REJECT_WIDTH = DEF_REJECT_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg,
  input  bank_req_t req,
  output out_word_t res
);

  localparam int KIND_W = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

  logic [CAP_W-1:0]        cap_r [NUM_KINDS];
  logic [CAP_W-1:0]        occ_r [NUM_KINDS];
  logic [REJECT_WIDTH-1:0] rej_r [NUM_KINDS];

  logic                    kind_ok;
  logic                    upd_en;
  logic [KIND_W-1:0]       kind_sel;
  logic [CAP_W-1:0]        occ_cur;
  logic [CAP_W-1:0]        cap_cur;
  logic [REJECT_WIDTH-1:0] rej_cur;
  logic [CAP_W-1:0]        occ_nxt;
  logic [REJECT_WIDTH-1:0] rej_nxt;
  logic [63:0]             rej_ext;
  logic [2:0]              status;
  logic                    cfg_ok;
  logic [KIND_W-1:0]       cfg_sel;

  assign kind_ok  = {1'b0, req.word.kind_index} < CFG_IDX_W'(NUM_KINDS);
  assign upd_en   = req.en && kind_ok;
  assign kind_sel = KIND_W'(req.word.kind_index);
  assign occ_cur  = occ_r[kind_sel];
  assign cap_cur  = cap_r[kind_sel];
  assign rej_cur  = rej_r[kind_sel];

  assign cfg_ok  = cfg.we && (cfg.index < CFG_IDX_W'(NUM_KINDS)) &&
                   (cfg.data != '0) && (cfg.data <= CAP_W'(MAX_CAPACITY));
  assign cfg_sel = KIND_W'(cfg.index);

  always_comb begin
    occ_nxt = occ_cur;
    rej_nxt = rej_cur;
    status  = ST_SNAPSHOT;
    unique case (req.word.cmd)
      CMD_ACQUIRE: begin
        if (occ_cur >= cap_cur) begin
          status = ST_FULL;
          if (rej_cur != '1) begin
            rej_nxt = rej_cur + 1'b1;
          end
        end else begin
          status  = ST_ACCEPTED;
          occ_nxt = occ_cur + 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (occ_cur == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          status  = ST_RELEASED;
          occ_nxt = occ_cur - 1'b1;
        end
      end
      default: begin
        status = ST_SNAPSHOT;
      end
    endcase
  end

  assign rej_ext = 64'(rej_nxt);

  always_comb begin
    res.status = status;
    if (kind_ok) begin
      res.occupancy_out = occ_nxt;
      res.capacity_out  = cap_cur;
      res.rejected_out  = rej_ext[REJ_OUT_W-1:0];
    end else begin
      unique case (req.word.cmd)
        CMD_ACQUIRE: res.status = ST_FULL;
        CMD_RELEASE: res.status = ST_UNDERFLOW;
        default:     res.status = ST_SNAPSHOT;
      endcase
      res.occupancy_out = '0;
      res.capacity_out  = '0;
      res.rejected_out  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KINDS; i++) begin
        cap_r[i] <= CAP_W'(1);
        occ_r[i] <= '0;
        rej_r[i] <= '0;
      end
    end else begin
      if (cfg_ok) begin
        cap_r[cfg_sel] <= cfg.data;
      end
      if (upd_en) begin
        occ_r[kind_sel] <= occ_nxt;
        rej_r[kind_sel] <= rej_nxt;
      end
    end
  end

  `ASSERT_IMP(a_grant_in_range, upd_en && status == ST_ACCEPTED, occ_nxt != '0 && occ_nxt <= cap_cur)
  `ASSERT_IMP(a_underflow_empty, upd_en && status == ST_UNDERFLOW, occ_cur == '0)
  `ASSERT_NXT(a_reject_counted, upd_en && status == ST_FULL, rej_r[$past(kind_sel)] != '0)

endmodule

[src/per_kind_occupancy_ledger.sv]
// ----------------------------------------------------------------------------
// Per-kind occupancy ledger
// Bank of resource credit counters with acquire, release and snapshot words.
// ----------------------------------------------------------------------------
// Each input word passes through an input register, then decode and counter
// update in the bank, into the result register, so a word is taken every
// cycle while the output is not stalled by out_ready; the single
// read-modify-write of the flop-based counter bank lets back-to-back words
// to the same kind see each other's updates.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module per_kind_occupancy_ledger import pkol_pkg::*; #(
  parameter int NUM_KINDS    = DEF_NUM_KINDS,
  parameter int MAX_CAPACITY = DEF_MAX_CAPACITY,
  parameter int REJECT_WIDTH = DEF_REJECT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAP_W-1:0]     cfg_data
);

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      advance;
  cfg_wr_t   cfg;
  bank_req_t req;
  out_word_t res;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign cfg.we    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign req.en   = s1_valid_r && advance;
  assign req.word = s1_word_r;

  pkol_bank #(
    .NUM_KINDS    (NUM_KINDS),
    .MAX_CAPACITY (MAX_CAPACITY),
    .REJECT_WIDTH (REJECT_WIDTH)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .req   (req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_data;
    end
    if (req.en) begin
      out_word_r <= res;
    end
  end

  `ASSERT_NXT(a_update_gives_result, req.en, out_valid_r)

endmodule
